// ===== src/bore_pkg.sv =====
`timescale 1ns / 1ps
// Package for the box overlay rectangle expander.
// Holds the job record passed from the front to the back, opcodes and fixed limits.
package bore_pkg;

    localparam int MAX_GLYPHS       = 31;
    localparam int RECTS_PER_TARGET = 5;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QAW              = $clog2(QUEUE_DEPTH);
    localparam int QCW              = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_STYLE  = 1'b0,
        OP_TARGET = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        PART_TOP    = 3'd0,
        PART_BOTTOM = 3'd1,
        PART_LEFT   = 3'd2,
        PART_RIGHT  = 3'd3,
        PART_LABEL  = 3'd4
    } t_part;

    localparam logic KIND_STRIP = 1'b0;
    localparam logic KIND_LABEL = 1'b1;
    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_REJ   = 1'b1;

    typedef struct packed {
        logic        ok;
        logic [15:0] box_x;
        logic [15:0] box_y;
        logic [15:0] box_w;
        logic [15:0] box_h;
        logic [15:0] lbl_x;
        logic [15:0] lbl_y;
        logic [15:0] lbl_w;
        logic [15:0] lbl_h;
        logic [15:0] stroke;
        logic [7:0]  tnum;
        logic [3:0]  slot;
    } t_job;

endpackage

// ===== src/bore_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts items, holds the style table and styles_loaded, checks targets.
// Depends on bore_pkg; pushes checked jobs into bore_queue.
module bore_front import bore_pkg::*; #(
    parameter int STYLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [3:0]  i_style_slot,
    input  logic [63:0] i_style_word,
    input  logic [15:0] i_box_x,
    input  logic [15:0] i_box_y,
    input  logic [15:0] i_box_width,
    input  logic [15:0] i_box_height,
    input  logic [15:0] i_label_left,
    input  logic [15:0] i_label_top,
    input  logic [4:0]  i_glyphs_in_label,
    input  logic [7:0]  i_target_number,
    input  logic        i_cfg_valid,
    input  logic [4:0]  i_cfg_data,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    localparam int AW = (STYLE_DEPTH > 1) ? $clog2(STYLE_DEPTH) : 1;

    logic [63:0] r_table [STYLE_DEPTH];
    logic [4:0]  r_styles_loaded;
    logic        r_s1_vld;
    logic [63:0] r_style;
    logic [3:0]  r_slot;
    logic [15:0] r_bx, r_by, r_bw, r_bh, r_lx, r_ly;
    logic [4:0]  r_glyphs;
    logic [7:0]  r_tnum;

    logic          accept;
    logic          slot_in_range;
    logic [AW+3:0] idx_wide;
    logic [AW-1:0] idx;

    assign o_in_ready    = !r_s1_vld || i_job_ready;
    assign accept        = i_in_valid && o_in_ready;
    assign slot_in_range = int'(i_style_slot) < STYLE_DEPTH;
    assign idx_wide      = {{AW{1'b0}}, i_style_slot};
    assign idx           = idx_wide[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld        <= 1'b0;
            r_styles_loaded <= 5'd0;
        end else begin
            if (i_cfg_valid) begin
                r_styles_loaded <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid && (t_opcode'(i_opcode) == OP_TARGET);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (t_opcode'(i_opcode) == OP_STYLE) && slot_in_range) begin
            r_table[idx] <= i_style_word;
        end
        if (accept && (t_opcode'(i_opcode) == OP_TARGET)) begin
            r_style  <= r_table[idx];
            r_slot   <= i_style_slot;
            r_bx     <= i_box_x;
            r_by     <= i_box_y;
            r_bw     <= i_box_width;
            r_bh     <= i_box_height;
            r_lx     <= i_label_left;
            r_ly     <= i_label_top;
            r_glyphs <= i_glyphs_in_label;
            r_tnum   <= i_target_number;
        end
    end

    logic [15:0] stroke, pad, adv, lh;
    logic [20:0] adv_prod;
    logic [21:0] lw;
    logic [15:0] half_w, half_h, s_w;
    logic [16:0] x_end, y_end, ly_end;
    logic [22:0] lx_end;
    logic        slot_ok, glyph_ok, size_ok, room_ok;

    assign stroke   = r_style[15:0];
    assign pad      = r_style[31:16];
    assign adv      = r_style[47:32];
    assign lh       = r_style[63:48];
    assign adv_prod = adv * r_glyphs;
    assign lw       = {5'd0, pad, 1'b0} + {1'b0, adv_prod};

    assign slot_ok  = ({1'b0, r_slot} < r_styles_loaded) && (int'(r_slot) < STYLE_DEPTH);
    assign glyph_ok = {3'd0, r_glyphs} <= 8'(MAX_GLYPHS);
    assign size_ok  = (r_bw >= 16'd2) && (r_bh >= 16'd2) && (lw != 22'd0);
    assign x_end    = {1'b0, r_bx} + {1'b0, r_bw};
    assign y_end    = {1'b0, r_by} + {1'b0, r_bh};
    assign lx_end   = {7'd0, r_lx} + {1'b0, lw};
    assign ly_end   = {1'b0, r_ly} + {1'b0, lh};
    assign room_ok  = (x_end <= 17'h0FFFF) && (y_end <= 17'h0FFFF)
                   && (lx_end <= 23'h00FFFF) && (ly_end <= 17'h0FFFF);

    // stroke is clamped to half the box in each direction
    assign half_w = {1'b0, r_bw[15:1]};
    assign half_h = {1'b0, r_bh[15:1]};
    assign s_w    = (half_w < stroke) ? half_w : stroke;

    always_comb begin
        o_job.ok     = slot_ok && glyph_ok && size_ok && room_ok;
        o_job.box_x  = r_bx;
        o_job.box_y  = r_by;
        o_job.box_w  = r_bw;
        o_job.box_h  = r_bh;
        o_job.lbl_x  = r_lx;
        o_job.lbl_y  = r_ly;
        o_job.lbl_w  = lw[15:0];
        o_job.lbl_h  = lh;
        o_job.stroke = (half_h < s_w) ? half_h : s_w;
        o_job.tnum   = r_tnum;
        o_job.slot   = r_slot;
    end

    assign o_job_valid = r_s1_vld;

endmodule

// ===== src/bore_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between the front and back ends.
// Depends on bore_pkg for the job record and depth.
module bore_queue import bore_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_job i_wr_data,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_job o_rd_data
);

    t_job           r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           push, pop;

    assign o_wr_ready = r_count != QCW'(QUEUE_DEPTH);
    assign o_rd_valid = r_count != '0;
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== src/bore_back.sv =====
`timescale 1ns / 1ps
// Back end: expands each queued job into strips and a label, or one reject item.
// Depends on bore_pkg; drives the registered result channel.
module bore_back import bore_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_rect_left,
    output logic [15:0] o_rect_top,
    output logic [15:0] o_rect_width,
    output logic [15:0] o_rect_height,
    output logic        o_instance_kind,
    output logic [7:0]  o_owner_target,
    output logic [3:0]  o_owner_style,
    output logic        o_status,
    output logic        o_last_of_target
);

    t_part       r_part;
    logic        r_out_vld;
    logic [15:0] r_left, r_top, r_width, r_height;
    logic        r_kind, r_status, r_last;
    logic [7:0]  r_tnum;
    logic [3:0]  r_slot;

    logic        load, done;
    logic [15:0] n_left, n_top, n_width, n_height;
    logic        n_kind, n_last;

    assign load        = i_job_valid && (!r_out_vld || i_out_ready);
    assign done        = !i_job.ok || (r_part == PART_LABEL);
    assign o_job_ready = load && done;

    always_comb begin
        n_left   = i_job.box_x;
        n_top    = i_job.box_y;
        n_width  = i_job.box_w;
        n_height = i_job.box_h;
        n_kind   = KIND_STRIP;
        n_last   = 1'b0;
        if (!i_job.ok) begin
            n_left   = '0;
            n_top    = '0;
            n_width  = '0;
            n_height = '0;
            n_last   = 1'b1;
        end else begin
            unique case (r_part)
                PART_TOP: begin
                    n_height = i_job.stroke;
                end
                PART_BOTTOM: begin
                    n_top    = i_job.box_y + i_job.box_h - i_job.stroke;
                    n_height = i_job.stroke;
                end
                PART_LEFT: begin
                    n_width = i_job.stroke;
                end
                PART_RIGHT: begin
                    n_left  = i_job.box_x + i_job.box_w - i_job.stroke;
                    n_width = i_job.stroke;
                end
                PART_LABEL: begin
                    n_left   = i_job.lbl_x;
                    n_top    = i_job.lbl_y;
                    n_width  = i_job.lbl_w;
                    n_height = i_job.lbl_h;
                    n_kind   = KIND_LABEL;
                    n_last   = 1'b1;
                end
                default: begin
                    n_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part    <= PART_TOP;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_out_vld <= 1'b1;
                r_part    <= done ? PART_TOP : t_part'(r_part + 3'd1);
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left   <= n_left;
            r_top    <= n_top;
            r_width  <= n_width;
            r_height <= n_height;
            r_kind   <= n_kind;
            r_status <= i_job.ok ? STAT_OK : STAT_REJ;
            r_last   <= n_last;
            r_tnum   <= i_job.tnum;
            r_slot   <= i_job.slot;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_rect_left      = r_left;
    assign o_rect_top       = r_top;
    assign o_rect_width     = r_width;
    assign o_rect_height    = r_height;
    assign o_instance_kind  = r_kind;
    assign o_owner_target   = r_tnum;
    assign o_owner_style    = r_slot;
    assign o_status         = r_status;
    assign o_last_of_target = r_last;

endmodule

// ===== src/box_overlay_rect_expander.sv =====
`timescale 1ns / 1ps
// Box overlay rectangle expander, top level.
// Instantiates bore_front, bore_queue and bore_back; uses bore_pkg.
//
// Input channel (i_in_valid / o_in_ready): opcode 0 writes a style entry and
// gives no result; opcode 1 is a target, expanded into four outline strips
// (top, bottom, left, right) and a label rectangle, or one reject item.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) sets styles_loaded;
// write it only while the block is idle.
// Result channel (o_out_valid / i_out_ready) is driven from an output register.
// A target's results pass the front-end register, the job queue and the output
// register in that order. Throughput: the back end emits one rectangle a cycle
// while the receiver is ready, five per target (one if rejected). The front end
// accepts a new item each cycle while the two-entry job queue has room, so it
// keeps working while the receiver stalls.
// Reset clears the queue, the output register and styles_loaded; the style
// table holds no defined value until written.
module box_overlay_rect_expander import bore_pkg::*; #(
    parameter int STYLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [3:0]  i_style_slot,
    input  logic [63:0] i_style_word,
    input  logic [15:0] i_box_x,
    input  logic [15:0] i_box_y,
    input  logic [15:0] i_box_width,
    input  logic [15:0] i_box_height,
    input  logic [15:0] i_label_left,
    input  logic [15:0] i_label_top,
    input  logic [4:0]  i_glyphs_in_label,
    input  logic [7:0]  i_target_number,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_rect_left,
    output logic [15:0] o_rect_top,
    output logic [15:0] o_rect_width,
    output logic [15:0] o_rect_height,
    output logic        o_instance_kind,
    output logic [7:0]  o_owner_target,
    output logic [3:0]  o_owner_style,
    output logic        o_status,
    output logic        o_last_of_target
);

    logic fq_valid, fq_ready, qb_valid, qb_ready;
    t_job fq_job, qb_job;

    assign o_cfg_ready = 1'b1;

    bore_front #(
        .STYLE_DEPTH(STYLE_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_style_slot     (i_style_slot),
        .i_style_word     (i_style_word),
        .i_box_x          (i_box_x),
        .i_box_y          (i_box_y),
        .i_box_width      (i_box_width),
        .i_box_height     (i_box_height),
        .i_label_left     (i_label_left),
        .i_label_top      (i_label_top),
        .i_glyphs_in_label(i_glyphs_in_label),
        .i_target_number  (i_target_number),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_job_valid      (fq_valid),
        .i_job_ready      (fq_ready),
        .o_job            (fq_job)
    );

    bore_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_valid(fq_valid),
        .o_wr_ready(fq_ready),
        .i_wr_data (fq_job),
        .o_rd_valid(qb_valid),
        .i_rd_ready(qb_ready),
        .o_rd_data (qb_job)
    );

    bore_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (qb_valid),
        .o_job_ready     (qb_ready),
        .i_job           (qb_job),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_rect_left     (o_rect_left),
        .o_rect_top      (o_rect_top),
        .o_rect_width    (o_rect_width),
        .o_rect_height   (o_rect_height),
        .o_instance_kind (o_instance_kind),
        .o_owner_target  (o_owner_target),
        .o_owner_style   (o_owner_style),
        .o_status        (o_status),
        .o_last_of_target(o_last_of_target)
    );

endmodule
